/* sv/bfbc_pkg.sv */
package bfbc_pkg;

  // Index and age fields are sized for the largest table (256 slots).
  localparam int unsigned SLOT_W = 8;

  localparam logic [31:0] ALIGN_MASK    = 32'd63;
  localparam logic [31:0] MAX_ROUNDABLE = 32'hFFFF_FFC0;
  localparam logic [31:0] LIMIT_RESET   = 32'd1048576;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RECYCLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_REUSED    = 3'd0,
    ST_ALLOC_NEW = 3'd1,
    ST_INVALID   = 3'd2,
    ST_KEPT      = 3'd3,
    ST_DROPPED   = 3'd4
  } status_e;

  // Best-fit candidate and first free slot, passed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [31:0]       size;
    logic [SLOT_W-1:0] age;
    logic [SLOT_W-1:0] idx;
    logic [63:0]       handle;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } cand_t;

  localparam cand_t CAND_EMPTY = '{default: '0};

  // Table update broadcast to every cell at the end of an item.
  typedef struct packed {
    logic              take;
    logic              put;
    logic [SLOT_W-1:0] sel_idx;
    logic [SLOT_W-1:0] ref_age;
    logic [31:0]       new_size;
    logic [63:0]       new_handle;
  } upd_t;

endpackage

/* sv/bfbc_cell.sv */
module bfbc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          cap_i,
  input  bfbc_pkg::cand_t      cand_i,
  output bfbc_pkg::cand_t      cand_o,
  input  bfbc_pkg::upd_t       upd_i,
  output logic                 valid_o
);

  logic                          valid_q, valid_d;
  logic [31:0]                   size_q;
  logic [63:0]                   handle_q;
  logic [bfbc_pkg::SLOT_W-1:0]   age_q, age_d;
  bfbc_pkg::cand_t               cand_q, cand_d;
  logic                          fits, better, hit_me;

  assign hit_me = (upd_i.sel_idx == bfbc_pkg::SLOT_W'(IDX));

  // Local compare against the candidate handed in from the left.
  always_comb begin
    fits   = valid_q && (size_q >= cap_i);
    better = fits && (!cand_i.found || (size_q < cand_i.size) ||
                      ((size_q == cand_i.size) && (age_q < cand_i.age)));
    cand_d = cand_i;
    if (better) begin
      cand_d.found  = 1'b1;
      cand_d.size   = size_q;
      cand_d.age    = age_q;
      cand_d.idx    = bfbc_pkg::SLOT_W'(IDX);
      cand_d.handle = handle_q;
    end
    if (!cand_i.free_found && !valid_q) begin
      cand_d.free_found = 1'b1;
      cand_d.free_idx   = bfbc_pkg::SLOT_W'(IDX);
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (upd_i.take) begin
      if (valid_q && (age_q > upd_i.ref_age)) begin
        age_d = age_q - 1'b1;
      end
      if (hit_me) begin
        valid_d = 1'b0;
      end
    end else if (upd_i.put) begin
      if (hit_me) begin
        valid_d = 1'b1;
        age_d   = '0;
      end else if (valid_q) begin
        age_d = age_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    age_q  <= age_d;
    if (upd_i.put && hit_me) begin
      size_q   <= upd_i.new_size;
      handle_q <= upd_i.new_handle;
    end
  end

  assign cand_o  = cand_q;
  assign valid_o = valid_q;

endmodule

/* sv/best_fit_block_cache_unit.sv */
// Best-fit block cache. Start an item by raising start_i while busy_o is
// low; the item is taken at that clock edge. Acquire (op_i = 0) rounds
// request_bytes_i up to a multiple of 64 and takes the smallest cached
// block that fits, newest first among equal sizes; recycle (op_i = 1)
// files block_size_i/block_handle_i if the cached total stays within
// cache_limit and a slot is free. Every item gives exactly one result:
// done_o is high for one cycle with status_o, granted_size_o and
// granted_handle_o, and the receiver cannot stall it. The search runs as
// a candidate passed down a row of MAX_BLOCKS slot cells, one cell per
// cycle, and done_o is registered from the last cell's candidate; a new
// item cannot start until busy_o drops, which happens in the cycle done_o
// is shown. Write cache_limit only while idle.
module best_fit_block_cache_unit #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item handshake
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] block_size_i,
  input  logic [63:0] block_handle_i,
  // result strobe
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_size_o,
  output logic [63:0] granted_handle_o,
  // configuration
  input  logic        cache_limit_we_i,
  input  logic [31:0] cache_limit_i
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  // control
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, finish;

  // captured item
  logic        op_q;
  logic        bad_q;
  logic [31:0] cap_q;
  logic [31:0] bsize_q;
  logic [63:0] bhandle_q;
  logic [31:0] cap_d;
  logic        bad_d;

  // table totals and limit
  logic [31:0] limit_q;
  logic [31:0] total_q, total_d;
  logic        fits_limit;

  // result registers
  logic                  done_q;
  bfbc_pkg::status_e     status_q, status_d;
  logic [31:0]           gsize_q, gsize_d;
  logic [63:0]           ghandle_q, ghandle_d;

  // cell row
  bfbc_pkg::cand_t       cand [MAX_BLOCKS+1];
  bfbc_pkg::cand_t       last;
  bfbc_pkg::upd_t        upd;
  logic [MAX_BLOCKS-1:0] slot_vld;

  assign accept = start_i && !busy_q;
  assign finish = busy_q && (cnt_q == CNT_W'(MAX_BLOCKS));
  assign last   = cand[MAX_BLOCKS];

  // Round up to 64; zero or an unroundable count is rejected.
  assign bad_d = (request_bytes_i == '0) || (request_bytes_i > bfbc_pkg::MAX_ROUNDABLE);
  assign cap_d = (request_bytes_i + bfbc_pkg::ALIGN_MASK) & ~bfbc_pkg::ALIGN_MASK;

  // 33-bit check so the sum cannot wrap.
  assign fits_limit = ({1'b0, total_q} + {1'b0, bsize_q}) <= {1'b0, limit_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Result and table update, decided in the last scan cycle.
  always_comb begin
    upd            = '0;
    upd.ref_age    = last.age;
    upd.new_size   = bsize_q;
    upd.new_handle = bhandle_q;
    total_d        = total_q;
    status_d       = bfbc_pkg::ST_DROPPED;
    gsize_d        = '0;
    ghandle_d      = '0;
    if (op_q == bfbc_pkg::OP_ACQUIRE) begin
      upd.sel_idx = last.idx;
      if (bad_q) begin
        status_d = bfbc_pkg::ST_INVALID;
      end else if (last.found) begin
        status_d  = bfbc_pkg::ST_REUSED;
        gsize_d   = last.size;
        ghandle_d = last.handle;
        upd.take  = finish;
        if (finish) begin
          total_d = total_q - last.size;
        end
      end else begin
        status_d = bfbc_pkg::ST_ALLOC_NEW;
        gsize_d  = cap_q;
      end
    end else begin
      upd.sel_idx = last.free_idx;
      if (last.free_found && fits_limit) begin
        status_d = bfbc_pkg::ST_KEPT;
        upd.put  = finish;
        if (finish) begin
          total_d = total_q + bsize_q;
        end
      end
    end
  end

  assign cand[0] = bfbc_pkg::CAND_EMPTY;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bfbc_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cap_i   (cap_q),
      .cand_i  (cand[g]),
      .cand_o  (cand[g+1]),
      .upd_i   (upd),
      .valid_o (slot_vld[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      limit_q <= bfbc_pkg::LIMIT_RESET;
      total_q <= '0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      done_q  <= finish;
      total_q <= total_d;
      if (cache_limit_we_i) begin
        limit_q <= cache_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      bad_q     <= bad_d;
      cap_q     <= cap_d;
      bsize_q   <= block_size_i;
      bhandle_q <= block_handle_i;
    end
    if (finish) begin
      status_q  <= status_d;
      gsize_q   <= gsize_d;
      ghandle_q <= ghandle_d;
    end
  end

  assign busy_o           = busy_q;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_size_o   = gsize_q;
  assign granted_handle_o = ghandle_q;

  // The result strobe comes only after the scan has closed.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result shown while an item is still in flight");

  // The slot table holds still while the candidate walks the row.
  a_table_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !finish) |=> $stable(slot_vld))
    else $error("slot table changed during a scan");

  // A reused block always fits a nonzero rounded request.
  a_reuse_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == bfbc_pkg::ST_REUSED)) |-> (gsize_q != '0))
    else $error("reused block of size zero");

  // Table changes by at most one slot per item.
  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (($countones(slot_vld) == $countones($past(slot_vld))) ||
                ($countones(slot_vld) == $countones($past(slot_vld)) + 1) ||
                ($countones(slot_vld) + 1 == $countones($past(slot_vld)))))
    else $error("more than one slot changed in one item");

endmodule

/* verif/best_fit_block_cache_unit_tb.sv */
`timescale 1ns / 100ps

// Best-fit block cache: directed table first, then seven random phases.
// Each phase runs with its own cache_limit.
module best_fit_block_cache_unit_tb;
  import bfbc_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 240;
  // Idle time at the end of the run, sized from the table depth.
  localparam int SETTLE      = TABLE_SLOTS + 4;
  // Watchdog bound; the slowest legal run, about 1700 items with the largest gaps, stays under it.
  localparam int RUN_LIMIT   = 400000;

  typedef struct {
    status_e     status;
    logic [31:0] size;
    logic [63:0] handle;
  } grant_t;

  // One row of the directed table. When fixed is set, the expected result
  // is typed in by hand. Otherwise the row goes through the shadow model.
  typedef struct {
    op_e         op;
    logic [31:0] req;
    logic [31:0] bsize;
    logic [63:0] handle;
    bit          fixed;
    grant_t      want;
  } row_t;

  // ---------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // ---------------------------------------------------------------------
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        start_i          = 1'b0;
  logic        op_i             = 1'b0;
  logic [31:0] request_bytes_i  = '0;
  logic [31:0] block_size_i     = '0;
  logic [63:0] block_handle_i   = '0;
  logic        cache_limit_we_i = 1'b0;
  logic [31:0] cache_limit_i    = '0;
  logic        busy_o;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] granted_size_o;
  logic [63:0] granted_handle_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  best_fit_block_cache_unit #(
    .MAX_BLOCKS(TABLE_SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .request_bytes_i (request_bytes_i),
    .block_size_i    (block_size_i),
    .block_handle_i  (block_handle_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_size_o  (granted_size_o),
    .granted_handle_o(granted_handle_o),
    .cache_limit_we_i(cache_limit_we_i),
    .cache_limit_i   (cache_limit_i)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the block table, updated as each item is accepted
  // ---------------------------------------------------------------------
  bit          cache_valid  [TABLE_SLOTS] = '{default: 1'b0};
  logic [31:0] cache_size   [TABLE_SLOTS];
  logic [63:0] cache_handle [TABLE_SLOTS];
  int          cache_age    [TABLE_SLOTS];   // 0 = most recently recycled
  logic [31:0] cached_bytes = '0;
  logic [31:0] limit_shadow = LIMIT_RESET;

  grant_t pending_grants[$];
  row_t   directed_rows[$];
  grant_t oldest;
  int     error_count = 0;
  int     cycle_count = 0;

  function automatic void predict_grant(input op_e op, input logic [31:0] req,
                                        input logic [31:0] bsz, input logic [63:0] hnd,
                                        output grant_t g);
    int          i;
    int          best;
    int          slot;
    logic [31:0] need;
    g    = '{status: ST_INVALID, size: '0, handle: '0};
    best = -1;
    slot = -1;
    if (op == OP_ACQUIRE) begin
      // zero request, or one that cannot be rounded without wrapping
      if (req == 32'd0 || req > MAX_ROUNDABLE) return;
      need = (req + ALIGN_MASK) & ~ALIGN_MASK;
      // smallest block that fits; on a size tie, the newer block wins
      for (i = 0; i < TABLE_SLOTS; i++) begin
        if (cache_valid[i] && cache_size[i] >= need) begin
          if (best < 0 || cache_size[i] < cache_size[best] ||
              (cache_size[i] == cache_size[best] && cache_age[i] < cache_age[best]))
            best = i;
        end
      end
      if (best < 0) begin
        g.status = ST_ALLOC_NEW;
        g.size   = need;
        return;
      end
      cache_valid[best] = 1'b0;
      cached_bytes     -= cache_size[best];
      // close the gap in the recency ranks
      for (i = 0; i < TABLE_SLOTS; i++)
        if (cache_valid[i] && cache_age[i] > cache_age[best]) cache_age[i]--;
      g.status = ST_REUSED;
      g.size   = cache_size[best];
      g.handle = cache_handle[best];
    end else begin
      for (i = TABLE_SLOTS - 1; i >= 0; i--)
        if (!cache_valid[i]) slot = i;
      // limit check at 33 bits so the sum cannot wrap
      if (slot < 0 || ({1'b0, cached_bytes} + {1'b0, bsz}) > {1'b0, limit_shadow}) begin
        g.status = ST_DROPPED;
        return;
      end
      for (i = 0; i < TABLE_SLOTS; i++)
        if (cache_valid[i]) cache_age[i]++;
      cache_valid[slot]  = 1'b1;
      cache_size[slot]   = bsz;
      cache_handle[slot] = hnd;
      cache_age[slot]    = 0;
      cached_bytes      += bsz;
      g.status = ST_KEPT;
    end
  endfunction

  function automatic void log_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endfunction

  function automatic void add_row(input op_e op, input logic [31:0] req,
                                  input logic [31:0] bsz, input logic [63:0] hnd,
                                  input bit fixed = 1'b0, input status_e st = ST_REUSED,
                                  input logic [31:0] sz = '0, input logic [63:0] h = '0);
    row_t r;
    r.op     = op;
    r.req    = req;
    r.bsize  = bsz;
    r.handle = hnd;
    r.fixed  = fixed;
    r.want   = '{status: st, size: sz, handle: h};
    directed_rows.push_back(r);
  endfunction

  // Called just after a rising edge. The task waits out the gap, presents the
  // item, and holds start until an edge sees busy low. It then returns, still
  // in the step of that accepting edge, with the shadow model's prediction.
  // With gap = 0, start stays high from one item to the next.
  task automatic issue_item(input op_e op, input logic [31:0] req, input logic [31:0] bsz,
                            input logic [63:0] hnd, input int gap, output grant_t g);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    op_i            <= op;
    request_bytes_i <= req;
    block_size_i    <= bsz;
    block_handle_i  <= hnd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_grant(op, req, bsz, hnd, g);
  endtask

  // Let every outstanding item finish, then wait out the extra idle time.
  task automatic settle_idle(input int extra);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cache_limit_we_i <= 1'b1;
    cache_limit_i    <= value;
    @(posedge clk_i);
    cache_limit_we_i <= 1'b0;
    limit_shadow      = value;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: a strobe is sampled at the edge that ends its cycle
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        log_error($sformatf("unexpected result: status %0d size %h handle %h",
                            status_o, granted_size_o, granted_handle_o));
      end else begin
        oldest = pending_grants.pop_front();
        if (status_o !== oldest.status || granted_size_o !== oldest.size ||
            granted_handle_o !== oldest.handle)
          log_error($sformatf({"mismatch: expected status %0d size %h handle %h, ",
                               "got status %0d size %h handle %h"},
                              oldest.status, oldest.size, oldest.handle,
                              status_o, granted_size_o, granted_handle_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    grant_t      g;
    op_e         op;
    logic [31:0] req;
    logic [31:0] bsz;
    logic [63:0] hnd;
    logic [31:0] new_limit;
    int          gap;
    int          pick;
    int          recycle_pct;
    bit          steady;

    // Directed table. It runs at the reset limit (1 MiB) on an empty table.
    // Request extremes: zero, all ones, just past and exactly at the rounding edge.
    add_row(OP_ACQUIRE, 32'd0,           '0, '0, 1'b1, ST_INVALID);
    add_row(OP_ACQUIRE, 32'hFFFF_FFFF,   '0, '0, 1'b1, ST_INVALID);
    add_row(OP_ACQUIRE, 32'hFFFF_FFC1,   '0, '0, 1'b1, ST_INVALID);
    add_row(OP_ACQUIRE, MAX_ROUNDABLE,   '0, '0, 1'b1, ST_ALLOC_NEW, MAX_ROUNDABLE);
    // largest block breaks the limit
    add_row(OP_RECYCLE, '0, MAX_ROUNDABLE, '1, 1'b1, ST_DROPPED);
    add_row(OP_RECYCLE, '0, 32'd128, 64'hFFFF_FFFF_FFFF_FFC0, 1'b1, ST_KEPT);
    // a zero-size block is kept but can never be matched
    add_row(OP_RECYCLE, '0, 32'd0,   64'd0,                  1'b1, ST_KEPT);
    // odd size is stored unrounded
    add_row(OP_RECYCLE, '0, 32'd100, 64'h0000_0000_0000_1234, 1'b1, ST_KEPT);
    add_row(OP_RECYCLE, '0, 32'd128, 64'hA5A5_5A5A_A5A5_5A5A, 1'b1, ST_KEPT);
    add_row(OP_ACQUIRE, 32'd65, '0, '0);    // two 128s tie: newer one wins
    add_row(OP_ACQUIRE, 32'd1,  '0, '0);    // best fit is the odd 100
    // recycle that brings the cached total exactly to the limit, then take it back
    add_row(OP_RECYCLE, '0, LIMIT_RESET - 32'd128, 64'h8000_0000_0000_0000);
    add_row(OP_ACQUIRE, LIMIT_RESET - 32'd128, '0, '0);
    // fill the table with 64-byte blocks; the last one finds no free slot
    for (int k = 0; k < 15; k++)
      add_row(OP_RECYCLE, '0, 32'd64, 64'h0000_7F00_0000_0000 + 64'(k) * 64'h40);
    add_row(OP_ACQUIRE, 32'd64, '0, '0);    // equal sizes: newest slot wins

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      gap = $urandom_range(0, 12);
      issue_item(directed_rows[r].op, directed_rows[r].req, directed_rows[r].bsize,
                 directed_rows[r].handle, gap, g);
      if (directed_rows[r].fixed) pending_grants.push_back(directed_rows[r].want);
      else pending_grants.push_back(g);
    end

    // Random phases, each with its own limit. The limit is written only
    // once the block has drained.
    steady = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      start_i <= 1'b0;
      settle_idle(4);
      case (phase)
        0: new_limit = 32'hFFFF_FFFF;
        1: new_limit = 32'd4096;
        2: new_limit = cached_bytes >> 1;          // below what is already cached
        3: new_limit = 32'd0;
        4: new_limit = $urandom_range(2048, 65536);
        5: new_limit = LIMIT_RESET;
        default: new_limit = $urandom;
      endcase
      write_limit(new_limit);
      recycle_pct = $urandom_range(40, 65);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // some runs of 32 items go back to back with no gaps
        if (n % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        gap = steady ? 0 : $urandom_range(0, 12);

        op = ($urandom_range(1, 100) <= recycle_pct) ? OP_RECYCLE : OP_ACQUIRE;
        // Requests are mostly small so that they hit cached blocks.
        // A few are zero, near the rounding limit, or full 32-bit values.
        pick = $urandom_range(0, 9);
        case (pick)
          7:       req = $urandom;
          8:       req = $urandom_range(MAX_ROUNDABLE - 256, 32'hFFFF_FFFF);
          9:       req = $urandom_range(0, 3);
          default: req = $urandom_range(1, 1600);
        endcase
        // Sizes are mostly multiples of 64. Some are odd, a few huge. Sizes
        // under 64 are left out: no request can match them, so they would
        // fill slots for good.
        pick = $urandom_range(0, 9);
        case (pick)
          7, 8:    bsz = $urandom_range(64, 1600);
          9:       bsz = $urandom_range(64, MAX_ROUNDABLE);
          default: bsz = 32'd64 * $urandom_range(1, 25);
        endcase
        hnd = {$urandom, $urandom};

        issue_item(op, req, bsz, hnd, gap, g);
        pending_grants.push_back(g);
      end
    end

    start_i <= 1'b0;
    settle_idle(SETTLE);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bfbc_pkg.sv
sv/bfbc_cell.sv
sv/best_fit_block_cache_unit.sv
verif/best_fit_block_cache_unit_tb.sv
